// File: sv/windowed_crc_checksum_verifier_unit_assert.svh
// Assertion macros shared by the checksum verifier RTL.
`ifndef WINDOWED_CRC_CHECKSUM_VERIFIER_UNIT_ASSERT_SVH
`define WINDOWED_CRC_CHECKSUM_VERIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WCCV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define WCCV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/wccv_pkg.sv
// Package: types, constants and CRC byte functions of the checksum verifier.
`timescale 1ns / 1ps

package wccv_pkg;

	localparam longint unsigned MAX_BUFFER_BYTES = 64'd65536;

	localparam int WIN_W  = 17;
	localparam int TYPE_W = 2;
	localparam int IDX_W  = 2;

	localparam logic [31:0] POLY32 = 32'h82F6_3B78;
	localparam logic [31:0] ONES32 = 32'hFFFF_FFFF;
	localparam logic [63:0] POLY64 = 64'h42F0_E1EB_A9EA_3693;

	localparam logic [TYPE_W-1:0] CK_CRC32C = 2'd0;
	localparam logic [TYPE_W-1:0] CK_CRC64  = 2'd1;

	localparam logic [IDX_W-1:0] REG_CHECKSUM_TYPE = 2'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW_START  = 2'd1;
	localparam logic [IDX_W-1:0] REG_WINDOW_END    = 2'd2;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [63:0] stored_value;
	} in_item_t;

	typedef struct packed {
		logic        verified;
		logic [63:0] computed_checksum;
		logic        window_fault;
	} out_item_t;

	typedef struct packed {
		logic [TYPE_W-1:0] checksum_type;
		logic [WIN_W-1:0]  window_start;
		logic [WIN_W-1:0]  window_end;
	} cfg_t;

	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? (POLY32 ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [63:0] crc64_byte(input logic [63:0] crc, input logic [7:0] b);
		logic [63:0] c;
		c = crc ^ {b, 56'd0};
		for (int i = 0; i < 8; i++) begin
			c = c[63] ? ((c << 1) ^ POLY64) : (c << 1);
		end
		return c;
	endfunction

endpackage

// File: sv/windowed_crc_checksum_verifier_unit.sv
// Top level of the windowed CRC32C / CRC-64/ECMA checksum verifier.
//
//   channel  direction  handshake           payload
//   src      in         src_valid/stall     wccv_pkg::in_item_t (one byte)
//   res      out        res_valid/stall     wccv_pkg::out_item_t (last byte only)
//   cfg      in         cfg_valid/ready     cfg_index, cfg_data
//
// One byte per cycle unless a last byte waits on a stalled result; a byte sits
// in the input register, where the CRC byte networks and the verify compare
// run, and a last byte's result sits in the output register from the next cycle.
// Reset clears the buffer state and the registers to type CRC32C, empty window.
// A stalled result holds only last bytes back; other bytes keep moving.
`timescale 1ns / 1ps
`include "windowed_crc_checksum_verifier_unit_assert.svh"

module windowed_crc_checksum_verifier_unit #(
	parameter longint unsigned MAX_BUFFER_BYTES = wccv_pkg::MAX_BUFFER_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            src_valid,
	output logic                            src_stall,
	input  wccv_pkg::in_item_t              src_item,
	output logic                            res_valid,
	input  logic                            res_stall,
	output wccv_pkg::out_item_t             res_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wccv_pkg::IDX_W-1:0]      cfg_index,
	input  logic [wccv_pkg::WIN_W-1:0]      cfg_data
);

	wccv_pkg::cfg_t      cfg_q;
	wccv_pkg::in_item_t  item_s1;
	wccv_pkg::out_item_t res_item_q;
	wccv_pkg::out_item_t core_res;
	logic                valid_s1;
	logic                res_valid_q;
	logic                out_free, adv_s1, emit;

	assign cfg_ready = 1'b1;
	assign out_free  = !res_valid_q || !res_stall;
	assign adv_s1    = valid_s1 && (!item_s1.last_byte || out_free);
	assign emit      = adv_s1 && item_s1.last_byte;
	assign src_stall = valid_s1 && !adv_s1;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{checksum_type: wccv_pkg::CK_CRC32C, window_start: '0, window_end: '0};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wccv_pkg::REG_CHECKSUM_TYPE:
					cfg_q.checksum_type <= cfg_data[wccv_pkg::TYPE_W-1:0];
				wccv_pkg::REG_WINDOW_START: cfg_q.window_start <= cfg_data;
				wccv_pkg::REG_WINDOW_END:   cfg_q.window_end   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!src_stall) begin
				valid_s1 <= src_valid;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
		if (emit) begin
			res_item_q <= core_res;
		end
	end

	wccv_core #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (adv_s1),
		.item  (item_s1),
		.cfg   (cfg_q),
		.result(core_res)
	);

	`WCCV_ASSERT_NOW(a_stall_needs_item, src_stall, valid_s1 && item_s1.last_byte,
		"input stalled without a waiting last byte")
	`WCCV_ASSERT_NOW(a_fault_zero, res_valid_q && res_item_q.window_fault,
		!res_item_q.verified && res_item_q.computed_checksum == 64'd0,
		"faulted result carries checksum or pass")
	`WCCV_ASSERT_NEXT(a_emit_shows, emit, res_valid_q, "result lost after last byte")

endmodule

// File: sv/wccv_core.sv
// Per-buffer state, CRC update and verify result logic.
`timescale 1ns / 1ps
`include "windowed_crc_checksum_verifier_unit_assert.svh"

module wccv_core #(
	parameter longint unsigned MAX_BUFFER_BYTES = wccv_pkg::MAX_BUFFER_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  wccv_pkg::in_item_t  item,
	input  wccv_pkg::cfg_t      cfg,
	output wccv_pkg::out_item_t result
);

	localparam int PosW = $clog2(MAX_BUFFER_BYTES + 64'd1);
	localparam int CmpW = (PosW > wccv_pkg::WIN_W) ? PosW : wccv_pkg::WIN_W;
	localparam logic [PosW-1:0] MaxPos = PosW'(MAX_BUFFER_BYTES);

	logic [PosW-1:0] pos_q, pos_n;
	logic            ovf_q, ovf_n;
	logic [31:0]     crc32_q, crc32_n;
	logic [63:0]     crc64_q, crc64_n;
	logic            sat, in_win, fault, is32;
	logic [CmpW-1:0] pos_x, start_x, end_x, len_x;
	logic [31:0]     fin32;

	always_comb begin
		sat     = (pos_q == MaxPos);
		pos_x   = CmpW'(pos_q);
		start_x = CmpW'(cfg.window_start);
		end_x   = CmpW'(cfg.window_end);
		in_win  = !sat && (pos_x >= start_x) && (pos_x < end_x);
		crc32_n = in_win ? wccv_pkg::crc32c_byte(crc32_q, item.data_byte) : crc32_q;
		crc64_n = in_win ? wccv_pkg::crc64_byte(crc64_q, item.data_byte) : crc64_q;
		pos_n   = sat ? pos_q : pos_q + PosW'(1);
		ovf_n   = ovf_q || sat;
		len_x   = CmpW'(pos_n);
		is32    = (cfg.checksum_type == wccv_pkg::CK_CRC32C);
		fault   = ovf_n || (start_x > end_x) || (end_x > len_x)
			|| !(is32 || (cfg.checksum_type == wccv_pkg::CK_CRC64));
		fin32   = crc32_n ^ wccv_pkg::ONES32;
		result.window_fault = fault;
		if (fault) begin
			result.computed_checksum = 64'd0;
			result.verified          = 1'b0;
		end else if (is32) begin
			result.computed_checksum = {32'd0, fin32};
			result.verified          = (fin32 == item.stored_value[31:0]);
		end else begin
			result.computed_checksum = crc64_n;
			result.verified          = (crc64_n == item.stored_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			crc32_q <= wccv_pkg::ONES32;
			crc64_q <= 64'd0;
		end else if (step) begin
			if (item.last_byte) begin
				pos_q   <= '0;
				ovf_q   <= 1'b0;
				crc32_q <= wccv_pkg::ONES32;
				crc64_q <= 64'd0;
			end else begin
				pos_q   <= pos_n;
				ovf_q   <= ovf_n;
				crc32_q <= crc32_n;
				crc64_q <= crc64_n;
			end
		end
	end

	`WCCV_ASSERT_NOW(a_pos_bounded, 1'b1, pos_q <= MaxPos, "byte position above maximum")
	`WCCV_ASSERT_NOW(a_ovf_saturated, ovf_q, pos_q == MaxPos, "overflow without saturated count")
	`WCCV_ASSERT_NEXT(a_clear_after_last, step && item.last_byte,
		pos_q == '0 && !ovf_q && crc32_q == wccv_pkg::ONES32 && crc64_q == 64'd0,
		"buffer state not cleared after last byte")

endmodule

// File: tb/windowed_crc_checksum_verifier_unit_tb.sv
// Self-checking bench for the windowed CRC32C / CRC-64/ECMA checksum verifier unit.
`timescale 1ns / 1ps

module windowed_crc_checksum_verifier_unit_tb;

	typedef logic [wccv_pkg::WIN_W-1:0] win_t;
	typedef logic [wccv_pkg::TYPE_W-1:0] kind_code_t;

	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int unsigned BUF_CAP = int'(wccv_pkg::MAX_BUFFER_BYTES);
	localparam logic [wccv_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam kind_code_t CK_UNKNOWN = 2'd2;
	localparam kind_code_t CK_RESERVED = 2'd3;
	localparam win_t WIN_MAX = '1;
	localparam logic [63:0] CRC32C_CHECK = 64'hFFFF_FFFF_E306_9283;

	typedef enum {STORE_RANDOM, STORE_MATCH, STORE_NEAR} stored_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	wccv_pkg::in_item_t src_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	wccv_pkg::out_item_t res_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [wccv_pkg::IDX_W-1:0] cfg_index = '0;
	win_t cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count = 0;
	int mismatch_count = 0;

	kind_code_t sel_type = wccv_pkg::CK_CRC32C;
	win_t win_lo = '0;
	win_t win_hi = '0;
	int unsigned byte_pos = 0;
	bit overflowed = 1'b0;
	logic [31:0] crc32_acc = wccv_pkg::ONES32;
	logic [63:0] crc64_acc = '0;
	wccv_pkg::out_item_t verdict_q[$];

	windowed_crc_checksum_verifier_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item(src_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("windowed_crc_checksum_verifier_unit regression: fail");
			$finish;
		end
	end

	function automatic logic [31:0] crc32c_step(logic [31:0] c, logic [7:0] b);
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ b[i]) begin
				c = (c >> 1) ^ wccv_pkg::POLY32;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [63:0] crc64_step(logic [63:0] c, logic [7:0] b);
		for (int i = 0; i < 8; i++) begin
			if (c[63] ^ b[7 - i]) begin
				c = (c << 1) ^ wccv_pkg::POLY64;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	function automatic bit counted(int unsigned p);
		return p >= win_lo && p < win_hi;
	endfunction

	// Stored value that the block should accept if this byte ends the buffer.
	function automatic logic [63:0] matching_stored(logic [7:0] b);
		logic [31:0] c32;
		logic [63:0] c64;
		c32 = crc32_acc;
		c64 = crc64_acc;
		if (byte_pos < BUF_CAP && counted(byte_pos)) begin
			c32 = crc32c_step(c32, b);
			c64 = crc64_step(c64, b);
		end
		if (sel_type == wccv_pkg::CK_CRC32C) begin
			return {$urandom(), ~c32};
		end
		return c64;
	endfunction

	task automatic absorb_byte(wccv_pkg::in_item_t it);
		wccv_pkg::out_item_t v;
		bit fault;
		if (byte_pos >= BUF_CAP) begin
			overflowed = 1'b1;
		end else begin
			if (counted(byte_pos)) begin
				crc32_acc = crc32c_step(crc32_acc, it.data_byte);
				crc64_acc = crc64_step(crc64_acc, it.data_byte);
			end
			byte_pos++;
		end
		if (it.last_byte) begin
			fault = overflowed || win_lo > win_hi || win_hi > byte_pos ||
				sel_type > wccv_pkg::CK_CRC64;
			v.window_fault = fault;
			v.computed_checksum = '0;
			v.verified = 1'b0;
			if (!fault && sel_type == wccv_pkg::CK_CRC32C) begin
				v.computed_checksum = {32'd0, ~crc32_acc};
				v.verified = (~crc32_acc == it.stored_value[31:0]);
			end else if (!fault) begin
				v.computed_checksum = crc64_acc;
				v.verified = (crc64_acc == it.stored_value);
			end
			verdict_q.push_back(v);
			byte_pos = 0;
			overflowed = 1'b0;
			crc32_acc = wccv_pkg::ONES32;
			crc64_acc = '0;
		end
	endtask

	always @(posedge clk) begin
		wccv_pkg::out_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (verdict_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result transfer: %p", res_item);
				end
			end else begin
				want = verdict_q.pop_front();
				if (res_item.verified !== want.verified ||
						res_item.computed_checksum !== want.computed_checksum ||
						res_item.window_fault !== want.window_fault) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result mismatch: expected verified=%0b sum=%h fault=%0b",
							want.verified, want.computed_checksum, want.window_fault);
						$display("                 actual   verified=%0b sum=%h fault=%0b",
							res_item.verified, res_item.computed_checksum,
							res_item.window_fault);
					end
				end
			end
		end
	end

	task automatic send_byte(logic [7:0] b, bit last, logic [63:0] stored, stored_kind_t how);
		wccv_pkg::in_item_t it;
		it.data_byte = b;
		it.last_byte = last;
		it.stored_value = stored;
		if (last && how != STORE_RANDOM) begin
			it.stored_value = matching_stored(b);
			if (how == STORE_NEAR) begin
				it.stored_value = it.stored_value ^ (64'd1 << $urandom_range(63));
			end
		end
		while ($urandom_range(99) < send_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= it;
		// hold the transfer until the block takes it
		@(posedge clk);
		while (src_stall) @(posedge clk);
		absorb_byte(it);
	endtask

	task automatic send_buffer(int len, stored_kind_t how);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom), i == len - 1, {$urandom, $urandom}, how);
		end
	endtask

	task automatic settle();
		src_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [wccv_pkg::IDX_W-1:0] idx, win_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			wccv_pkg::REG_CHECKSUM_TYPE: sel_type = data[wccv_pkg::TYPE_W-1:0];
			wccv_pkg::REG_WINDOW_START: win_lo = data;
			wccv_pkg::REG_WINDOW_END: win_hi = data;
			default: ;
		endcase
	endtask

	task automatic load_regs(kind_code_t t, win_t lo, win_t hi);
		settle();
		write_reg(wccv_pkg::REG_CHECKSUM_TYPE, {15'($urandom), t});
		write_reg(wccv_pkg::REG_WINDOW_START, lo);
		write_reg(wccv_pkg::REG_WINDOW_END, hi);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_crc32c_vector();
		load_regs(wccv_pkg::CK_CRC32C, 0, 9);
		for (int i = 0; i < 9; i++) begin
			send_byte(8'h31 + 8'(i), i == 8, CRC32C_CHECK, STORE_RANDOM);
		end
	endtask

	task automatic test_crc64_match();
		load_regs(wccv_pkg::CK_CRC64, 0, 3);
		send_byte(8'hFF, 1'b0, '1, STORE_RANDOM);
		send_byte(8'h00, 1'b0, '0, STORE_RANDOM);
		send_byte(8'h80, 1'b1, '0, STORE_MATCH);
	endtask

	task automatic test_window_edges();
		load_regs(wccv_pkg::CK_CRC32C, 1, 2);
		send_byte(8'h00, 1'b0, '0, STORE_RANDOM);
		send_byte(8'hFF, 1'b0, '0, STORE_RANDOM);
		send_byte(8'h5A, 1'b1, '1, STORE_RANDOM);
		// empty window that ends exactly at the buffer length
		load_regs(wccv_pkg::CK_CRC64, 2, 2);
		send_byte(8'hFF, 1'b0, '1, STORE_RANDOM);
		send_byte(8'h00, 1'b1, '0, STORE_RANDOM);
	endtask

	task automatic test_window_faults();
		load_regs(wccv_pkg::CK_CRC32C, 1, 0);
		send_byte(8'hA5, 1'b1, '0, STORE_MATCH);
		load_regs(wccv_pkg::CK_CRC32C, 0, 2);
		send_byte(8'h3C, 1'b1, '0, STORE_MATCH);
		load_regs(CK_UNKNOWN, 0, 1);
		send_byte(8'hC3, 1'b1, '0, STORE_MATCH);
		load_regs(CK_RESERVED, 0, 1);
		send_byte(8'h81, 1'b1, '1, STORE_MATCH);
		load_regs(wccv_pkg::CK_CRC64, 0, WIN_MAX);
		send_byte(8'h7E, 1'b1, '0, STORE_MATCH);
		load_regs(wccv_pkg::CK_CRC64, WIN_MAX, WIN_MAX);
		send_byte(8'h18, 1'b1, '0, STORE_MATCH);
	endtask

	task automatic test_unused_register();
		settle();
		write_reg(wccv_pkg::REG_WINDOW_START, 0);
		write_reg(REG_UNUSED, WIN_MAX);
		write_reg(wccv_pkg::REG_WINDOW_END, 1);
		cfg_valid <= 1'b0;
		send_byte(8'h96, 1'b1, '0, STORE_MATCH);
	endtask

	task automatic test_random_buffers(int n_items);
		int sent;
		int len;
		bit reuse;
		kind_code_t t;
		win_t lo;
		win_t hi;
		stored_kind_t how;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			reuse = ($urandom_range(1) == 1) && win_hi <= len && win_lo <= win_hi &&
				sel_type <= wccv_pkg::CK_CRC64;
			if (!reuse) begin
				t = ($urandom_range(1) == 1) ? wccv_pkg::CK_CRC64 : wccv_pkg::CK_CRC32C;
				hi = win_t'($urandom_range(len));
				lo = win_t'($urandom_range(hi));
				case ($urandom_range(9))
					0: t = kind_code_t'($urandom_range(CK_UNKNOWN, CK_RESERVED));
					1: lo = win_t'($urandom_range(hi + 1, WIN_MAX));
					2: hi = win_t'($urandom_range(len + 1, WIN_MAX));
					default: ;
				endcase
				load_regs(t, lo, hi);
			end
			how = ($urandom_range(3) == 0) ? STORE_RANDOM :
				($urandom_range(2) == 0) ? STORE_NEAR : STORE_MATCH;
			send_buffer(len, how);
			sent += len;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 34;
		recv_idle_pct = 73;
		test_crc32c_vector();
		test_crc64_match();
		test_window_edges();
		test_window_faults();
		test_unused_register();
		test_random_buffers(140);
		send_idle_pct = 73;
		recv_idle_pct = 34;
		test_random_buffers(140);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_buffers(140);
		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("windowed_crc_checksum_verifier_unit regression: pass");
		end else begin
			$display("windowed_crc_checksum_verifier_unit regression: fail");
		end
		$finish;
	end

endmodule
